[rtl/core/tkh_pkg.sv]
// tkh_pkg: shared types, constants and word helpers of the keyed hash
package tkh_pkg;

  localparam int PARTIAL_ROUNDS = 6;
  localparam int FULL_ROUNDS    = 10;
  localparam int MAX_ROUNDS     = (FULL_ROUNDS > PARTIAL_ROUNDS) ? FULL_ROUNDS : PARTIAL_ROUNDS;
  localparam int ROUND_CNT_W    = $clog2(MAX_ROUNDS + 1);

  typedef logic [31:0]            word_t;
  typedef logic [127:0]           block_t;
  typedef logic [ROUND_CNT_W-1:0] round_cnt_t;
  typedef word_t                  words_t [4];
  typedef logic [0:0]             cfg_index_t;

  localparam word_t TEA_DELTA      = 32'h9E3779B9;
  localparam word_t KEY_ZERO_RESET = 32'h9464A485;
  localparam word_t KEY_ONE_RESET  = 32'h542E1A94;

  localparam round_cnt_t PARTIAL_LAST = round_cnt_t'(PARTIAL_ROUNDS - 1);
  localparam round_cnt_t FULL_LAST    = round_cnt_t'(FULL_ROUNDS - 1);

  localparam cfg_index_t CFG_KEY_ZERO = 1'b0;
  localparam cfg_index_t CFG_KEY_ONE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic round;
    logic finish;
    logic start_tail;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic full16;
    logic out_busy;
  } status_t;

  function automatic word_t sext_byte(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic word_t pad_of(input logic [30:0] len);
    word_t l;
    word_t p;
    l = {1'b0, len};
    p = l | (l << 8);
    return p | (p << 16);
  endfunction

  // little-endian word of sign-extended bytes, ORed together
  function automatic word_t load_word(input block_t blk, input logic [1:0] idx);
    word_t w;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      w = w | (sext_byte(blk[32*idx + 8*j +: 8]) << (8*j));
    end
    return w;
  endfunction

  function automatic word_t tail_word(input block_t blk, input logic [1:0] idx,
                                      input logic [3:0] cnt, input word_t pad);
    word_t w;
    w = pad;
    if (idx < cnt[3:2]) begin
      w = load_word(blk, idx);
    end else if (idx == cnt[3:2]) begin
      for (int j = 0; j < 3; j++) begin
        if (j < int'(cnt[1:0])) begin
          w = (w << 8) | sext_byte(blk[32*idx + 8*j +: 8]);
        end
      end
    end
    return w;
  endfunction

endpackage

[rtl/core/tkh_if.sv]
// tkh_in_if / tkh_out_if: valid-ready channels of the keyed hash
interface tkh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_low;
  logic [63:0] block_high;
  logic [4:0]  byte_count;
  logic [30:0] message_length;
  logic        first_block;
  logic        last_block;

  modport source (output valid, block_low, block_high, byte_count, message_length,
                  first_block, last_block, input ready);
  modport sink   (input valid, block_low, block_high, byte_count, message_length,
                  first_block, last_block, output ready);
endinterface

interface tkh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

[rtl/core/tea_keyed_hash_32_top.sv]
// tea_keyed_hash_32_top: tea davies-meyer keyed 32-bit hash over 16-byte blocks
// One block is taken at a time, and a single tea round unit does one round per cycle.
// A block that is not last goes through a load step, six rounds and a fold step.
// A last block of 0 to 15 bytes goes through load, ten rounds, fold and result; a
// last block of 16 bytes goes through the six-round mix, then ten rounds over an
// all-pad tail. The result sits in an output register; if it is still untaken when the
// next result is due, the block waits in its fold cycle. Key words written over cfg take
// effect at the next first block or after the next result.
module tea_keyed_hash_32_top (
  input  logic                clk,
  input  logic                rst_n,
  tkh_in_if.sink              in_chan,
  tkh_out_if.source           out_chan,
  input  logic                cfg_we,
  input  tkh_pkg::cfg_index_t cfg_index,
  input  tkh_pkg::word_t      cfg_wdata
);
  import tkh_pkg::*;

  cmd_t    cmd;
  status_t status;

  tkh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tkh_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .blk_low   (in_chan.block_low),
    .blk_high  (in_chan.block_high),
    .blk_count (in_chan.byte_count),
    .blk_len   (in_chan.message_length),
    .blk_first (in_chan.first_block),
    .blk_last  (in_chan.last_block),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_hash  (out_chan.hash_value)
  );

  // a new result only appears right after an emit
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(cmd.emit))
    else $error("result valid without emit");

  // never overwrite a result that has not been taken
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_chan.valid || out_chan.ready))
    else $error("emit over pending result");

  // no transfer in while the round unit is busy
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.round || cmd.finish || cmd.start_tail) |-> !in_chan.ready)
    else $error("input ready while mixing");

endmodule

[rtl/core/tkh_ctrl.sv]
// tkh_ctrl: sequencer for block load, tea rounds, fold and result
module tkh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tkh_pkg::status_t status,
  output tkh_pkg::cmd_t    cmd
);
  import tkh_pkg::*;

  state_t     state_r, state_nxt;
  round_cnt_t cnt_r, cnt_nxt;
  logic       tail_r, tail_nxt;
  logic       tail_now;
  round_cnt_t cnt_last;

  // tail phase: either the second mix of a full last block or a short last block
  assign tail_now = tail_r | (status.last & ~status.full16);
  assign cnt_last = tail_now ? FULL_LAST : PARTIAL_LAST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      tail_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      tail_r  <= tail_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    tail_nxt  = tail_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          tail_nxt  = 1'b0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cnt_nxt   = cnt_r + round_cnt_t'(1);
        if (cnt_r == cnt_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!tail_now) begin
          if (status.last) begin
            cmd.start_tail = 1'b1;
            tail_nxt       = 1'b1;
            cnt_nxt        = '0;
            state_nxt      = ST_ROUND;
          end else begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else if (!status.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/tkh_datapath.sv]
// tkh_datapath: key registers, hash halves, tea round unit and result register
module tkh_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tkh_pkg::cmd_t         cmd,
  output tkh_pkg::status_t      status,
  input  logic                  cfg_we,
  input  tkh_pkg::cfg_index_t   cfg_index,
  input  tkh_pkg::word_t        cfg_wdata,
  input  logic [63:0]           blk_low,
  input  logic [63:0]           blk_high,
  input  logic [4:0]            blk_count,
  input  logic [30:0]           blk_len,
  input  logic                  blk_first,
  input  logic                  blk_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tkh_pkg::word_t        out_hash
);
  import tkh_pkg::*;

  word_t  key0_r, key1_r;
  word_t  half0_r, half1_r;
  word_t  pad_r;
  word_t  b0_r, b1_r, sum_r;
  words_t w_r;
  logic   last_r, full16_r;
  logic   out_valid_r;
  word_t  out_hash_r;

  block_t blk;
  word_t  pad_sel, h0_sel, h1_sel;
  words_t w_load;
  logic   use_full;
  word_t  b0_rnd, b1_rnd;
  word_t  h0_fold, h1_fold;

  assign blk      = {blk_high, blk_low};
  assign pad_sel  = blk_first ? pad_of(blk_len) : pad_r;
  assign h0_sel   = blk_first ? key0_r : half0_r;
  assign h1_sel   = blk_first ? key1_r : half1_r;
  assign use_full = ~blk_last | blk_count[4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w_load[i] = use_full ? load_word(blk, 2'(i))
                           : tail_word(blk, 2'(i), blk_count[3:0], pad_sel);
    end
  end

  // one tea round; the second half uses the freshly updated first half
  always_comb begin
    b0_rnd = b0_r + (((b1_r << 4) + w_r[0]) ^ (b1_r + sum_r) ^ ((b1_r >> 5) + w_r[1]));
    b1_rnd = b1_r + (((b0_rnd << 4) + w_r[2]) ^ (b0_rnd + sum_r) ^ ((b0_rnd >> 5) + w_r[3]));
  end

  assign h0_fold = half0_r + b0_r;
  assign h1_fold = half1_r + b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r      <= KEY_ZERO_RESET;
      key1_r      <= KEY_ONE_RESET;
      half0_r     <= KEY_ZERO_RESET;
      half1_r     <= KEY_ONE_RESET;
      pad_r       <= '0;
      last_r      <= 1'b0;
      full16_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_ZERO: key0_r <= cfg_wdata;
          CFG_KEY_ONE:  key1_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        half0_r  <= h0_sel;
        half1_r  <= h1_sel;
        pad_r    <= pad_sel;
        last_r   <= blk_last;
        full16_r <= blk_count[4];
      end
      if (cmd.finish || cmd.start_tail) begin
        half0_r <= h0_fold;
        half1_r <= h1_fold;
      end
      if (cmd.emit) begin
        half0_r     <= key0_r;
        half1_r     <= key1_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b0_r  <= h0_sel;
      b1_r  <= h1_sel;
      sum_r <= TEA_DELTA;
      w_r   <= w_load;
    end else if (cmd.round) begin
      b0_r  <= b0_rnd;
      b1_r  <= b1_rnd;
      sum_r <= sum_r + TEA_DELTA;
    end else if (cmd.start_tail) begin
      // empty tail: every word is the pad
      b0_r  <= h0_fold;
      b1_r  <= h1_fold;
      sum_r <= TEA_DELTA;
      for (int i = 0; i < 4; i++) begin
        w_r[i] <= pad_r;
      end
    end
    if (cmd.emit) begin
      out_hash_r <= h0_fold ^ h1_fold;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hash        = out_hash_r;
  assign status.last     = last_r;
  assign status.full16   = full16_r;
  assign status.out_busy = out_valid_r & ~out_ready;

endmodule

[tb/sv/tb_top.sv]
// tb_top: self-checking testbench for the keyed tea hash, predicting each hash from the blocks sent
`timescale 1ns / 100ps

module tb_top;
  import tkh_pkg::*;

  localparam int SETTLE_CYCLES = 40;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BURSTY
  } rx_mode_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  cfg_index_t cfg_index;
  word_t      cfg_wdata;

  tkh_in_if  in_chan ();
  tkh_out_if out_chan ();

  tea_keyed_hash_32_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // predictor copy of keys, chaining halves and pad
  word_t key_a, key_b;
  word_t chain_a, chain_b;
  word_t pad_fill;

  word_t    hash_expect_q [$];
  word_t    hash_want;
  int       err_cnt    = 0;
  int       items_sent = 0;
  int       burst_left = 0;
  int       rx_tick    = 0;
  rx_mode_t rx_mode    = RX_OPEN;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic word_t sx8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  // sign-extended bytes are ORed, so a negative low byte floods the upper bits
  function automatic word_t le_word(input logic [127:0] blk, input int idx);
    word_t w;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      w = w | (sx8(blk[32*idx + 8*j +: 8]) << (8*j));
    end
    return w;
  endfunction

  function automatic void chain_rounds(input word_t w [4], input int rounds);
    word_t acc, b0, b1;
    acc = '0;
    b0  = chain_a;
    b1  = chain_b;
    for (int r = 0; r < rounds; r++) begin
      acc = acc + TEA_DELTA;
      b0  = b0 + (((b1 << 4) + w[0]) ^ (b1 + acc) ^ ((b1 >> 5) + w[1]));
      b1  = b1 + (((b0 << 4) + w[2]) ^ (b0 + acc) ^ ((b0 >> 5) + w[3]));
    end
    chain_a = chain_a + b0;
    chain_b = chain_b + b1;
  endfunction

  function automatic void predict_hash(input logic [63:0] lo, input logic [63:0] hi,
                                       input logic [4:0] cnt, input logic [30:0] len,
                                       input logic first, input logic last);
    logic [127:0] blk;
    word_t        w [4];
    word_t        p;
    int           c, nfull;
    blk = {hi, lo};
    c   = (cnt > 5'd16) ? 16 : int'(cnt);
    if (first) begin
      chain_a  = key_a;
      chain_b  = key_b;
      p        = {1'b0, len} | ({1'b0, len} << 8);
      pad_fill = p | (p << 16);
    end
    if (!last || c == 16) begin
      for (int i = 0; i < 4; i++) w[i] = le_word(blk, i);
      chain_rounds(w, PARTIAL_ROUNDS);
      if (!last) return;
      c = 0;
    end
    nfull = c / 4;
    for (int i = 0; i < 4; i++) begin
      if (i < nfull) begin
        w[i] = le_word(blk, i);
      end else begin
        w[i] = pad_fill;
        if (i == nfull) begin
          for (int k = 4*i; k < c; k++) w[i] = (w[i] << 8) | sx8(blk[8*k +: 8]);
        end
      end
    end
    chain_rounds(w, FULL_ROUNDS);
    hash_expect_q.push_back(chain_a ^ chain_b);
    chain_a = key_a;
    chain_b = key_b;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // receiver ready, switching among four randomly chosen patterns
  always @(posedge clk) begin
    rx_tick = rx_tick + 1;
    if (rx_tick % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_chan.ready <= 1'b1;
      RX_COIN:   out_chan.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_chan.ready <= ($urandom_range(0, 3) == 0);
      default:   out_chan.ready <= ((rx_tick % 16) >= 11);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (hash_expect_q.size() == 0) begin
        if (err_cnt < 10) $display("%0t: unexpected hash %h", $realtime, out_chan.hash_value);
        err_cnt++;
      end else begin
        hash_want = hash_expect_q.pop_front();
        if (out_chan.hash_value !== hash_want) begin
          if (err_cnt < 10) begin
            $display("%0t: hash mismatch, expected %h actual %h",
                     $realtime, hash_want, out_chan.hash_value);
          end
          err_cnt++;
        end
      end
    end
  end

  // one transfer on the input channel, with bursts and gaps
  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] cnt, input logic [30:0] len,
                            input logic first, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_chan.valid          <= 1'b1;
    in_chan.block_low      <= lo;
    in_chan.block_high     <= hi;
    in_chan.byte_count     <= cnt;
    in_chan.message_length <= len;
    in_chan.first_block    <= first;
    in_chan.last_block     <= last;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    predict_hash(lo, hi, cnt, len, first, last);
    items_sent++;
  endtask

  task automatic send_msg(input int nfull, input logic [4:0] inner_cnt,
                          input logic [4:0] tail_cnt, input logic first,
                          input logic [30:0] len);
    for (int i = 0; i < nfull; i++) begin
      send_block(rand64(), rand64(), inner_cnt, len, first && i == 0, 1'b0);
    end
    send_block(rand64(), rand64(), tail_cnt, len, first && nfull == 0, 1'b1);
  endtask

  // drop valid, drain all hashes, then let any non-last block finish
  task automatic settle_block();
    in_chan.valid <= 1'b0;
    while (hash_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(input cfg_index_t idx, input word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KEY_ZERO) key_a = val;
    else key_b = val;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    // no first block after reset: reset keys and a zero pad
    send_block({8{8'h80}}, {8{8'h80}}, 5'd3, 31'd3, 1'b0, 1'b1);
    send_block(64'h0, 64'h0, 5'd0, 31'd0, 1'b1, 1'b1);
    send_block('1, '1, 5'd16, 31'h7FFF_FFFF, 1'b1, 1'b1);
    send_block('1, '1, 5'd0, 31'h7FFF_FFFF, 1'b1, 1'b1);
  endtask

  task automatic test_tail_lengths();
    int lens [11];
    lens = '{1, 2, 3, 4, 5, 7, 8, 9, 12, 13, 15};
    foreach (lens[i]) begin
      send_block(64'h80FF_7F01_C37E_0080, 64'hFF80_017F_00A5_5AFF, 5'(lens[i]),
                 31'(lens[i] + 'h55), 1'b1, 1'b1);
    end
  endtask

  task automatic test_count_cases();
    // short count on an inner block is ignored, oversized count on the last means 16
    send_block(rand64(), rand64(), 5'd5, 31'd21, 1'b1, 1'b0);
    send_block(rand64(), rand64(), 5'd31, 31'd21, 1'b0, 1'b1);
    send_block(rand64(), rand64(), 5'd17, 31'd17, 1'b1, 1'b1);
  endtask

  task automatic test_message_chaining();
    send_block(rand64(), rand64(), 5'd16, 31'd40, 1'b1, 1'b0);
    send_block(rand64(), rand64(), 5'd16, 31'd40, 1'b0, 1'b0);
    send_block(rand64(), rand64(), 5'd8, 31'd40, 1'b0, 1'b1);
    // next message without a first block restarts from the keys, pad kept
    send_block(rand64(), rand64(), 5'd7, 31'd0, 1'b0, 1'b1);
    // first block in mid message restarts the chain
    send_block(rand64(), rand64(), 5'd16, 31'd99, 1'b1, 1'b0);
    send_block(rand64(), rand64(), 5'd2, 31'd18, 1'b1, 1'b1);
  endtask

  task automatic test_key_settings();
    word_t ka, kb;
    for (int s = 0; s < 5; s++) begin
      case (s)
        0:       begin ka = '0;              kb = '0;              end
        1:       begin ka = '1;              kb = '1;              end
        2:       begin ka = '0;              kb = '1;              end
        3:       begin ka = '1;              kb = '0;              end
        default: begin ka = $urandom;        kb = $urandom;        end
      endcase
      settle_block();
      write_key(CFG_KEY_ZERO, ka);
      write_key(CFG_KEY_ONE, kb);
      // halves were reloaded with the old keys at the last message end
      send_block(rand64(), rand64(), 5'd5, 31'd5, 1'b0, 1'b1);
      send_block(rand64(), rand64(), 5'($urandom_range(0, 16)), 31'($urandom), 1'b1, 1'b1);
      send_block(rand64(), rand64(), 5'd11, 31'd11, 1'b0, 1'b1);
    end
  endtask

  task automatic test_random_messages();
    int          kind, nfull, goal;
    logic [4:0]  tail, inner;
    logic        first;
    logic [30:0] len;
    for (int phase = 0; phase < 4; phase++) begin
      settle_block();
      if (phase == 3) begin
        write_key(CFG_KEY_ZERO, KEY_ZERO_RESET);
        write_key(CFG_KEY_ONE, KEY_ONE_RESET);
      end else begin
        write_key(CFG_KEY_ZERO, $urandom);
        if (phase != 1) write_key(CFG_KEY_ONE, $urandom);
      end
      goal = items_sent + 100;
      while (items_sent < goal) begin
        kind  = $urandom_range(0, 99);
        nfull = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
        tail  = 5'($urandom_range(0, 16));
        inner = 5'd16;
        first = 1'b1;
        if (kind >= 94) begin
          send_block(rand64(), rand64(), 5'($urandom_range(0, 31)), 31'($urandom),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          continue;
        end
        if (kind >= 88) begin
          inner = 5'($urandom_range(0, 15));
          if (nfull == 0) nfull = 1;
        end else if (kind >= 80) begin
          tail = 5'($urandom_range(17, 31));
        end else if (kind >= 70) begin
          first = 1'b0;
        end
        len = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'(16 * nfull + tail);
        send_msg(nfull, inner, tail, first, len);
      end
    end
  endtask

  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_KEY_ZERO;
    cfg_wdata              = '0;
    in_chan.valid          = 1'b0;
    in_chan.block_low      = '0;
    in_chan.block_high     = '0;
    in_chan.byte_count     = '0;
    in_chan.message_length = '0;
    in_chan.first_block    = 1'b0;
    in_chan.last_block     = 1'b0;
    out_chan.ready         = 1'b0;
    key_a                  = KEY_ZERO_RESET;
    key_b                  = KEY_ONE_RESET;
    chain_a                = KEY_ZERO_RESET;
    chain_b                = KEY_ONE_RESET;
    pad_fill               = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_tail_lengths();
    test_count_cases();
    test_message_chaining();
    test_key_settings();
    test_random_messages();

    settle_block();
    if (err_cnt == 0 && hash_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
